@@ rtl/core/pag_pkg.sv @@
// Shared types, constants and codes of the partition access guard.
`default_nettype none

package pag_pkg;

	// Table geometry
	localparam int PART_SLOTS = 32;
	localparam int SLOT_W     = $clog2(PART_SLOTS);
	localparam int ENTRY_W    = 5;
	localparam int CNT_W      = 6;
	localparam int MASK_W     = 32;
	localparam int SECT_W     = 32;

	// Protection bits per partition
	localparam logic [1:0] PROT_READ_BIT  = 2'b01;
	localparam logic [1:0] PROT_WRITE_BIT = 2'b10;

	// Partitions whose region ends at the next partition's start
	localparam logic [ENTRY_W-1:0] MBR_INDEX = 5'd0;
	localparam logic [ENTRY_W-1:0] EBR_INDEX = 5'd4;

	// Request actions
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_CHECK = 1'b1;

	// Configuration register indexes
	localparam logic [1:0] CFG_PART_COUNT = 2'd0;
	localparam logic [1:0] CFG_READ_MASK  = 2'd1;
	localparam logic [1:0] CFG_WRITE_MASK = 2'd2;

	// Configuration reset values
	localparam logic [CNT_W-1:0]  PART_COUNT_RST = 6'd0;
	localparam logic [MASK_W-1:0] READ_MASK_RST  = 32'd1230;
	localparam logic [MASK_W-1:0] WRITE_MASK_RST = 32'd4063;

	typedef struct packed {
		logic              action;
		logic [4:0]        entry_index;
		logic [SECT_W-1:0] entry_start;
		logic [SECT_W-1:0] entry_length;
		logic [SECT_W-1:0] req_start;
		logic [SECT_W-1:0] req_count;
		logic              is_write;
		logic              first_pass;
	} pag_in_t;

	typedef struct packed {
		logic              refused;
		logic [SECT_W-1:0] allowed_blocks;
		logic              partial_taken;
	} pag_out_t;

	// What a table read delivers
	typedef enum logic [1:0] {
		RD_NORMAL,
		RD_REGION_LO,
		RD_REGION_HI
	} rd_kind_t;

	// Controller to datapath
	typedef struct packed {
		logic               load;
		logic               check;
		logic               rd_en;
		logic [SLOT_W-1:0]  rd_addr;
		rd_kind_t           kind;
		logic [ENTRY_W-1:0] entry;
		logic               open_phase;
		logic               push;
	} pag_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic short_table;
	} pag_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/pag_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module pag_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pag_datapath.sv @@
// Datapath: config registers, partition table, region build, overlap test, result.
`default_nettype none

module pag_datapath (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pag_pkg::pag_in_t      in_data,
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [31:0]           cfg_wdata,
	input  wire pag_pkg::pag_cmd_t     cmd,
	output pag_pkg::pag_sts_t          sts,
	output pag_pkg::pag_out_t          out_data
);

	localparam int SW = pag_pkg::SECT_W;
	localparam int CW = pag_pkg::CNT_W;

	// Configuration registers
	logic [CW-1:0]              part_count_q;
	logic [pag_pkg::MASK_W-1:0] rd_mask_q;
	logic [pag_pkg::MASK_W-1:0] wr_mask_q;

	// Request registers
	logic [SW-1:0] s_q;
	logic [SW-1:0] e_q;
	logic [1:0]    dir_q;

	// Table read stage
	logic                        vld_s1;
	pag_pkg::rd_kind_t           kind_s1;
	logic [pag_pkg::ENTRY_W-1:0] entry_s1;
	logic                        open_s1;
	logic [2*SW-1:0]             rdata;
	logic [SW-1:0]               rd_start;
	logic [SW-1:0]               rd_len;
	logic [SW-1:0]               region_ps_q;
	logic [1:0]                  prot;
	logic                        in_tbl;
	logic                        use_entry;

	// Evaluate stage
	logic          vld_s2;
	logic          open_s2;
	logic [SW-1:0] ps_s2;
	logic [SW-1:0] pe_s2;

	// Result registers
	logic          go_partial_q;
	logic          hit_q;
	logic          refused_q;
	logic [SW-1:0] allowed_q;
	logic          short_q;

	logic [CW-1:0] len;
	logic          c_in;
	logic          c_end;
	logic          c_span;
	logic [SW-1:0] min_end;
	logic [SW-1:0] minuend;
	logic [SW-1:0] part_allowed;
	logic          ram_we;

	// Hold configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_count_q <= pag_pkg::PART_COUNT_RST;
			rd_mask_q    <= pag_pkg::READ_MASK_RST;
			wr_mask_q    <= pag_pkg::WRITE_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pag_pkg::CFG_PART_COUNT: part_count_q <= cfg_wdata[CW-1:0];
				pag_pkg::CFG_READ_MASK:  rd_mask_q    <= cfg_wdata;
				pag_pkg::CFG_WRITE_MASK: wr_mask_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Clamp table length to the slot count
	assign len = (part_count_q > CW'(pag_pkg::PART_SLOTS)) ?
		CW'(pag_pkg::PART_SLOTS) : part_count_q;

	assign sts.short_table = (len <= CW'(1));

	// Partition table: start in the upper half, length in the lower half
	assign ram_we = cmd.load && (int'(in_data.entry_index) < pag_pkg::PART_SLOTS);

	pag_ram #(
		.WIDTH (2 * SW),
		.DEPTH (pag_pkg::PART_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (pag_pkg::SLOT_W'(in_data.entry_index)),
		.wdata ({in_data.entry_start, in_data.entry_length}),
		.re    (cmd.rd_en),
		.raddr (cmd.rd_addr),
		.rdata (rdata)
	);

	assign rd_start = rdata[2*SW-1:SW];
	assign rd_len   = rdata[SW-1:0];

	// Latch the request
	always_ff @(posedge clk) begin
		if (cmd.check) begin
			s_q   <= in_data.req_start;
			e_q   <= in_data.req_start + in_data.req_count;
			dir_q <= in_data.is_write ? pag_pkg::PROT_WRITE_BIT : pag_pkg::PROT_READ_BIT;
		end
	end

	// Align read tags with read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1  <= cmd.kind;
		entry_s1 <= cmd.entry;
		open_s1  <= cmd.open_phase;
	end

	// Qualify the entry: inside the table and protected as this pass asks
	always_comb begin
		prot = {wr_mask_q[entry_s1], rd_mask_q[entry_s1]};
		if (kind_s1 == pag_pkg::RD_REGION_HI) begin
			in_tbl = ({1'b0, entry_s1} + CW'(1)) < len;
		end else begin
			in_tbl = {1'b0, entry_s1} < len;
		end
		if (open_s1) begin
			use_entry = (prot != 2'b00) && ((prot & dir_q) == 2'b00);
		end else begin
			use_entry = (prot & dir_q) != 2'b00;
		end
	end

	// Build the region of the entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1 && (kind_s1 != pag_pkg::RD_REGION_LO) && in_tbl && use_entry;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && kind_s1 == pag_pkg::RD_REGION_LO) begin
			region_ps_q <= rd_start;
		end
		open_s2 <= open_s1;
		if (kind_s1 == pag_pkg::RD_REGION_HI) begin
			ps_s2 <= region_ps_q;
			pe_s2 <= rd_start;
		end else begin
			ps_s2 <= rd_start;
			pe_s2 <= rd_start + rd_len;
		end
	end

	// Test the region against the request
	always_comb begin
		c_in         = (ps_s2 <= s_q) && (s_q < pe_s2);
		c_end        = (ps_s2 < e_q) && (e_q <= pe_s2);
		c_span       = (s_q < ps_s2) && (pe_s2 < e_q);
		min_end      = (e_q < pe_s2) ? e_q : pe_s2;
		minuend      = c_in ? min_end : ps_s2;
		part_allowed = minuend - s_q;
	end

	// Update the verdict; the first hit in table order wins
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_partial_q <= 1'b0;
			hit_q        <= 1'b0;
			refused_q    <= 1'b0;
			allowed_q    <= '0;
			short_q      <= 1'b0;
		end else if (cmd.check) begin
			go_partial_q <= !in_data.first_pass;
			hit_q        <= 1'b0;
			refused_q    <= 1'b0;
			allowed_q    <= in_data.req_count;
			short_q      <= sts.short_table;
		end else if (cmd.load) begin
			go_partial_q <= 1'b0;
			hit_q        <= 1'b0;
			refused_q    <= 1'b0;
			allowed_q    <= '0;
			short_q      <= 1'b0;
		end else if (vld_s2 && !hit_q) begin
			if (open_s2) begin
				if (c_in || c_end || c_span) begin
					go_partial_q <= 1'b1;
				end
			end else if (!go_partial_q) begin
				if (c_in || c_end || c_span) begin
					hit_q     <= 1'b1;
					refused_q <= 1'b1;
				end
			end else if (c_in || c_end || c_span) begin
				hit_q     <= 1'b1;
				refused_q <= c_in;
				allowed_q <= part_allowed;
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_data.refused        <= refused_q;
			out_data.allowed_blocks <= allowed_q;
			out_data.partial_taken  <= go_partial_q & ~short_q;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pag_ctrl.sv @@
// Controller: request intake, table read sequencing and result hand-off.
`default_nettype none

module pag_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pag_pkg::pag_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire pag_pkg::pag_sts_t sts,
	output pag_pkg::pag_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OPEN,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic [1:0]                  open_cnt_q;
	logic [pag_pkg::ENTRY_W-1:0] j_q;
	logic                        hi_q;
	logic                        drain_cnt_q;
	logic                        drain_to_scan_q;
	logic                        out_valid_q;
	logic                        region_entry;
	logic [pag_pkg::ENTRY_W-1:0] open_base;
	logic                        accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;

	assign region_entry = (j_q == pag_pkg::MBR_INDEX) || (j_q == pag_pkg::EBR_INDEX);
	assign open_base    = open_cnt_q[1] ? pag_pkg::EBR_INDEX : pag_pkg::MBR_INDEX;

	// Decode commands
	always_comb begin
		cmd            = '0;
		cmd.kind       = pag_pkg::RD_NORMAL;
		cmd.load       = accept && (in_data.action == pag_pkg::ACT_LOAD);
		cmd.check      = accept && (in_data.action == pag_pkg::ACT_CHECK);
		case (state_q)
			ST_OPEN: begin
				cmd.rd_en      = 1'b1;
				cmd.rd_addr    = pag_pkg::SLOT_W'(open_base) +
					pag_pkg::SLOT_W'(open_cnt_q[0]);
				cmd.kind       = open_cnt_q[0] ? pag_pkg::RD_REGION_HI : pag_pkg::RD_REGION_LO;
				cmd.entry      = open_base;
				cmd.open_phase = 1'b1;
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				cmd.entry = j_q;
				if (hi_q) begin
					cmd.rd_addr = pag_pkg::SLOT_W'(j_q) + pag_pkg::SLOT_W'(1);
					cmd.kind    = pag_pkg::RD_REGION_HI;
				end else if (region_entry) begin
					cmd.rd_addr = pag_pkg::SLOT_W'(j_q);
					cmd.kind    = pag_pkg::RD_REGION_LO;
				end else begin
					cmd.rd_addr = pag_pkg::SLOT_W'(j_q);
					cmd.kind    = pag_pkg::RD_NORMAL;
				end
			end
			ST_FINISH: begin
				cmd.push = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	// Sequence state and hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			open_cnt_q      <= '0;
			j_q             <= '0;
			hi_q            <= 1'b0;
			drain_cnt_q     <= 1'b0;
			drain_to_scan_q <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_FINISH;
					end else if (cmd.check) begin
						j_q        <= '0;
						hi_q       <= 1'b0;
						open_cnt_q <= '0;
						if (sts.short_table) begin
							state_q <= ST_FINISH;
						end else if (in_data.first_pass) begin
							state_q <= ST_OPEN;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_OPEN: begin
					open_cnt_q <= open_cnt_q + 2'd1;
					if (open_cnt_q == 2'd3) begin
						state_q         <= ST_DRAIN;
						drain_cnt_q     <= 1'b0;
						drain_to_scan_q <= 1'b1;
					end
				end
				ST_SCAN: begin
					if (hi_q) begin
						hi_q <= 1'b0;
						j_q  <= j_q + pag_pkg::ENTRY_W'(1);
					end else if (region_entry) begin
						hi_q <= 1'b1;
					end else begin
						j_q <= j_q + pag_pkg::ENTRY_W'(1);
						if (j_q == '1) begin
							state_q         <= ST_DRAIN;
							drain_cnt_q     <= 1'b0;
							drain_to_scan_q <= 1'b0;
						end
					end
				end
				ST_DRAIN: begin
					drain_cnt_q <= 1'b1;
					if (drain_cnt_q) begin
						j_q     <= '0;
						hi_q    <= 1'b0;
						state_q <= drain_to_scan_q ? ST_SCAN : ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.push) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/partition_access_guard.sv @@
// Partition access guard: checks sector requests against protected partitions.
//
// Input channel (in_valid/in_ready/in_data) takes one request: a load request
// writes one partition table slot, a check request asks whether a sector
// range may proceed. Output channel (out_valid/out_ready/out_data) returns
// exactly one result per request, in order; a load returns all zero.
// The cfg port (cfg_we/cfg_index/cfg_wdata) writes part_count or one of the
// two protection masks per write; write it only while the block is idle.
// Sequence, accept to result valid:
//   load, or check with fewer than two table entries: straight to result push
//   check with first_pass low: 34 table reads, read and compare drain,
//     result push
//   check with first_pass high: 4 extra reads for the MBR/EBR regions plus
//     their drain, before the scan above
// The table has one read port, so the scan reads one slot per cycle, and
// MBR/EBR regions take a second read for the following partition's start.
// One request is in work at a time: a request is accepted only while idle.
// in_ready returns as the result is pushed into the output register, so the
// next request enters while a result waits.
// A stalled receiver holds the block in its finish state.
// Reset restores the configuration registers; the table is not cleared.
`default_nettype none

module partition_access_guard (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire pag_pkg::pag_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output pag_pkg::pag_out_t      out_data,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [31:0]       cfg_wdata
);

	pag_pkg::pag_cmd_t cmd;
	pag_pkg::pag_sts_t sts;

	pag_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pag_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

	// Never overwrite a result that has not been taken
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (!out_valid || out_ready))
		else $error("result pushed over a pending result");

	// Table reads happen only while a request is in work
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !in_ready)
		else $error("table read while idle");

	// An accepted request keeps the block busy for the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("request accepted twice in a row");

	// A load never coincides with a table read
	a_load_no_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.rd_en)
		else $error("table write collides with scan");

endmodule

`default_nettype wire
